@@ hdl/pgr_pkg.sv @@
// Shared types and constants for the page replacement unit.
// Used by every module in the hdl folder; depends on nothing else.
package pgr_pkg;

  localparam int unsigned PAGE_W         = 16;
  localparam int unsigned FRAME_IDX_W    = 4;
  localparam int unsigned TOTAL_W        = 32;
  localparam int unsigned FRAMES_DEFAULT = 16;

  // Configuration port layout and register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned FRAMES_IN_USE_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

  localparam logic [FRAMES_IN_USE_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_e;

  // What the lookup decided for one reference.
  typedef struct packed {
    logic hit;
    logic fill;
    logic evict;
  } action_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;
  } in_item_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [TOTAL_W-1:0]     hit_total;
    logic [TOTAL_W-1:0]     miss_total;
    logic                   end_marker;
  } out_item_t;

endpackage

@@ hdl/page_replacement_fifo_lru_core.sv @@
// Top level of the FIFO / LRU page replacement unit.
// Depends on pgr_pkg, pgr_frame_select, pgr_frame_store and pgr_totals.
//
// Usage:
//   Each input beat on in_item_i carries one page reference. It is accepted at a
//   rising edge with in_valid_i high and in_stall_o low. Every accepted beat
//   produces exactly one result beat on out_item_o, taken at an edge with
//   out_valid_o high and out_stall_i low. Results come out in reference order.
//   An accepted beat sits in the input register, where the frame lookup, the victim
//   choice and the rank update run; once the result register is free the result is
//   loaded into it, so each result passes through the input and output registers.
//   One beat per cycle is sustained while the receiver does not stall, since every
//   state update completes in the same edge that loads the result register.
//   When the receiver stalls, the result stays put and one more beat can wait in
//   the input register; only then is in_stall_o raised.
//   The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
//   is always ready. Index 0 selects the policy (0 FIFO, 1 LRU), index 1 the
//   number of frames in use; other indexes are ignored. Write only while idle.
//   Reset empties every frame, clears ranks and totals, points the FIFO pointer
//   at the last frame, and restores FIFO policy with sixteen frames in use.
module page_replacement_fifo_lru_core #(
  parameter int unsigned FRAMES = pgr_pkg::FRAMES_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pgr_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pgr_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pgr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pgr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Configuration registers.
  pgr_pkg::policy_e                         policy_q;
  logic [pgr_pkg::FRAMES_IN_USE_W-1:0]      frames_in_use_q;

  // Input and result registers.
  pgr_pkg::in_item_t                        in_q;
  logic                                     in_valid_q;
  pgr_pkg::out_item_t                       out_q, out_d;
  logic                                     out_valid_q;

  logic                                     out_free;
  logic                                     fire;

  // Frame state and lookup results.
  logic [FRAMES-1:0][pgr_pkg::PAGE_W-1:0]   frame_page;
  logic [FRAMES-1:0]                        frame_valid;
  logic [FRAMES-1:0][FW-1:0]                rank;
  logic [FW-1:0]                            fifo_ptr;
  logic [FW-1:0]                            fifo_ptr_d;
  pgr_pkg::action_t                         action;
  logic [FW-1:0]                            frame;
  logic [pgr_pkg::PAGE_W-1:0]               evicted_page;
  logic [pgr_pkg::TOTAL_W-1:0]              hit_next;
  logic [pgr_pkg::TOTAL_W-1:0]              miss_next;
  logic [FW+pgr_pkg::FRAME_IDX_W-1:0]       frame_ext;

  // The result register frees up when empty or when its beat is taken this edge.
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign fire       = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q        <= pgr_pkg::POLICY_FIFO;
      frames_in_use_q <= pgr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pgr_pkg::CFG_POLICY_MODE: begin
          policy_q <= pgr_pkg::policy_e'(cfg_data_i[0]);
        end
        pgr_pkg::CFG_FRAMES_IN_USE: begin
          frames_in_use_q <= cfg_data_i[pgr_pkg::FRAMES_IN_USE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  pgr_frame_select #(
    .FRAMES (FRAMES)
  ) u_select (
    .page_i          (in_q.page_number),
    .frames_in_use_i (frames_in_use_q),
    .policy_i        (policy_q),
    .frame_page_i    (frame_page),
    .frame_valid_i   (frame_valid),
    .rank_i          (rank),
    .fifo_ptr_i      (fifo_ptr),
    .action_o        (action),
    .frame_o         (frame),
    .fifo_ptr_d_o    (fifo_ptr_d),
    .evicted_page_o  (evicted_page)
  );

  pgr_frame_store #(
    .FRAMES (FRAMES)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (fire),
    .action_i      (action),
    .frame_i       (frame),
    .page_i        (in_q.page_number),
    .fifo_ptr_d_i  (fifo_ptr_d),
    .frame_page_o  (frame_page),
    .frame_valid_o (frame_valid),
    .rank_o        (rank),
    .fifo_ptr_o    (fifo_ptr)
  );

  pgr_totals u_totals (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_inc_i   (fire & action.hit),
    .miss_inc_i  (fire & ~action.hit),
    .hit_next_o  (hit_next),
    .miss_next_o (miss_next)
  );

  // Only the low four bits of the frame number are reported.
  assign frame_ext = {{pgr_pkg::FRAME_IDX_W{1'b0}}, frame};

  always_comb begin
    out_d.hit           = action.hit;
    out_d.frame_index   = frame_ext[pgr_pkg::FRAME_IDX_W-1:0];
    out_d.evicted_valid = action.evict;
    out_d.evicted_page  = evicted_page;
    out_d.hit_total     = hit_next;
    out_d.miss_total    = miss_next;
    out_d.end_marker    = in_q.last_reference;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hdl/pgr_frame_select.sv @@
// Combinational lookup: hit search, first empty frame, LRU and FIFO victim choice.
// Depends on pgr_pkg.
module pgr_frame_select #(
  parameter int unsigned FRAMES = pgr_pkg::FRAMES_DEFAULT
) (
  input  logic [pgr_pkg::PAGE_W-1:0]                         page_i,
  input  logic [pgr_pkg::FRAMES_IN_USE_W-1:0]                frames_in_use_i,
  input  pgr_pkg::policy_e                                   policy_i,
  input  logic [FRAMES-1:0][pgr_pkg::PAGE_W-1:0]             frame_page_i,
  input  logic [FRAMES-1:0]                                  frame_valid_i,
  input  logic [FRAMES-1:0][((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rank_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0]     fifo_ptr_i,
  output pgr_pkg::action_t                                   action_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0]     frame_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0]     fifo_ptr_d_o,
  output logic [pgr_pkg::PAGE_W-1:0]                         evicted_page_o
);

  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned MW = $clog2(FRAMES + 1);

  logic [MW-1:0]     active_cnt;
  logic [FRAMES-1:0] active;
  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] empty;
  logic [FRAMES-1:0] is_max;
  logic [FW-1:0]     hit_f;
  logic [FW-1:0]     empty_f;
  logic [FW-1:0]     lru_f;
  logic [FW:0]       fifo_inc;
  logic [FW-1:0]     fifo_next;

  // A count of zero acts as one, a count above the frame total acts as the total.
  always_comb begin
    if (frames_in_use_i == '0) begin
      active_cnt = MW'(1);
    end else if (32'(frames_in_use_i) > FRAMES) begin
      active_cnt = MW'(FRAMES);
    end else begin
      active_cnt = MW'(frames_in_use_i);
    end
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_frame
    assign active[g] = MW'(g) < active_cnt;
    assign match[g]  = active[g] & frame_valid_i[g] & (frame_page_i[g] == page_i);
    assign empty[g]  = active[g] & ~frame_valid_i[g];
  end

  // A frame is the LRU victim when no active frame ranks above it and no
  // lower-numbered active frame ties with it.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      is_max[i] = active[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (active[j]) begin
          if (j < i) begin
            if (rank_i[j] >= rank_i[i]) begin
              is_max[i] = 1'b0;
            end
          end else if (rank_i[j] > rank_i[i]) begin
            is_max[i] = 1'b0;
          end
        end
      end
    end
  end

  // Lowest-numbered frame wins in each search.
  always_comb begin
    hit_f   = '0;
    empty_f = '0;
    lru_f   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_f = FW'(i);
      end
      if (empty[i]) begin
        empty_f = FW'(i);
      end
      if (is_max[i]) begin
        lru_f = FW'(i);
      end
    end
  end

  assign fifo_inc  = {1'b0, fifo_ptr_i} + (FW + 1)'(1);
  assign fifo_next = (32'(fifo_inc) >= 32'(active_cnt)) ? '0 : fifo_inc[FW-1:0];

  always_comb begin
    action_o.hit   = |match;
    action_o.fill  = ~(|match) & (|empty);
    action_o.evict = ~(|match) & ~(|empty);

    if (action_o.hit) begin
      frame_o = hit_f;
    end else if (action_o.fill) begin
      frame_o = empty_f;
    end else if (policy_i == pgr_pkg::POLICY_LRU) begin
      frame_o = lru_f;
    end else begin
      frame_o = fifo_next;
    end

    if (action_o.fill) begin
      fifo_ptr_d_o = empty_f;
    end else if (action_o.evict && (policy_i == pgr_pkg::POLICY_FIFO)) begin
      fifo_ptr_d_o = fifo_next;
    end else begin
      fifo_ptr_d_o = fifo_ptr_i;
    end

    evicted_page_o = action_o.evict ? frame_page_i[frame_o] : '0;
  end

endmodule

@@ hdl/pgr_frame_store.sv @@
// Frame state: page numbers, valid bits, recency ranks and the FIFO pointer.
// Depends on pgr_pkg.
module pgr_frame_store #(
  parameter int unsigned FRAMES = pgr_pkg::FRAMES_DEFAULT
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               update_i,
  input  pgr_pkg::action_t                                   action_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0]     frame_i,
  input  logic [pgr_pkg::PAGE_W-1:0]                         page_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0]     fifo_ptr_d_i,
  output logic [FRAMES-1:0][pgr_pkg::PAGE_W-1:0]             frame_page_o,
  output logic [FRAMES-1:0]                                  frame_valid_o,
  output logic [FRAMES-1:0][((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rank_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0]     fifo_ptr_o
);

  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned RW = FW;

  logic [FRAMES-1:0][pgr_pkg::PAGE_W-1:0] page_q, page_d;
  logic [FRAMES-1:0]                      valid_q, valid_d;
  logic [FRAMES-1:0][RW-1:0]              rank_q, rank_d;
  logic [FW-1:0]                          ptr_q;
  logic [RW:0]                            old_rank;

  // An empty frame being filled counts as older than everything.
  assign old_rank = valid_q[frame_i] ? {1'b0, rank_q[frame_i]} : (RW + 1)'(FRAMES);

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    for (int i = 0; i < FRAMES; i++) begin
      if (FW'(i) == frame_i) begin
        rank_d[i] = '0;
      end else if (valid_q[i] && ({1'b0, rank_q[i]} < old_rank) &&
                   (32'(rank_q[i]) < FRAMES - 1)) begin
        rank_d[i] = rank_q[i] + RW'(1);
      end
    end
    if (action_i.fill) begin
      valid_d[frame_i] = 1'b1;
    end
    if (action_i.fill || action_i.evict) begin
      page_d[frame_i] = page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      valid_q <= '0;
      rank_q  <= '0;
      ptr_q   <= FW'(FRAMES - 1);
    end else if (update_i) begin
      page_q  <= page_d;
      valid_q <= valid_d;
      rank_q  <= rank_d;
      ptr_q   <= fifo_ptr_d_i;
    end
  end

  assign frame_page_o  = page_q;
  assign frame_valid_o = valid_q;
  assign rank_o        = rank_q;
  assign fifo_ptr_o    = ptr_q;

endmodule

@@ hdl/pgr_totals.sv @@
// Saturating hit and miss counters; the next values feed the result beat.
// Depends on pgr_pkg.
module pgr_totals (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        hit_inc_i,
  input  logic                        miss_inc_i,
  output logic [pgr_pkg::TOTAL_W-1:0] hit_next_o,
  output logic [pgr_pkg::TOTAL_W-1:0] miss_next_o
);

  logic [pgr_pkg::TOTAL_W-1:0] hit_q;
  logic [pgr_pkg::TOTAL_W-1:0] miss_q;

  assign hit_next_o  = (hit_inc_i && (hit_q != '1)) ? hit_q + 1'b1 : hit_q;
  assign miss_next_o = (miss_inc_i && (miss_q != '1)) ? miss_q + 1'b1 : miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= '0;
      miss_q <= '0;
    end else begin
      hit_q  <= hit_next_o;
      miss_q <= miss_next_o;
    end
  end

endmodule

@@ hdl/pgr_checker.sv @@
// Port-level checks for the page replacement unit, bound to its top level.
// Depends on pgr_pkg and page_replacement_fifo_lru_core.
module pgr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pgr_pkg::out_item_t out_item_o
);

  // A stalled result beat stays and does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed or dropped");

  // The input side only backs up behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // A hit never evicts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.evicted_valid |-> !out_item_o.hit)
    else $error("eviction reported on a hit");

  // Without an eviction the evicted page reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.evicted_valid |-> out_item_o.evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  // Every result counts itself in one of the totals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.hit_total != '0) || (out_item_o.miss_total != '0))
    else $error("result with both totals at zero");

endmodule

bind page_replacement_fifo_lru_core pgr_checker u_pgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ tb/sv/tb_page_replacement_fifo_lru_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for page_replacement_fifo_lru_core (FIFO / LRU frame replacement).
// Depends on pgr_pkg and the RTL under hdl; a scoreboard class predicts each result beat.
module tb_page_replacement_fifo_lru_core;
  import pgr_pkg::*;

  localparam int unsigned NFRAMES       = FRAMES_DEFAULT;
  // Nothing may be accepted on any channel for this many cycles before the run is abandoned.
  // The longest legal quiet stretch is the deliberate receiver hold-off below.
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned PHASE_REFS    = 125;
  // Results pass through the input and result registers; the settle time covers any beat in flight.
  localparam int unsigned SETTLE_CYCLES = 4;

  // Scoreboard: keeps its own copy of the frame table, ranks, FIFO pointer, totals and
  // configuration, predicts the result of each accepted reference and checks result beats
  // against those predictions in order.
  class residency_scoreboard;
    logic [PAGE_W-1:0]          page_of [NFRAMES];
    bit                         valid_of[NFRAMES];
    int unsigned                rank_of [NFRAMES];
    int unsigned                fifo_ptr;
    logic [TOTAL_W-1:0]         hits;
    logic [TOTAL_W-1:0]         misses;
    policy_e                    policy;
    logic [FRAMES_IN_USE_W-1:0] frames_cfg;
    out_item_t                  pending_outcomes[$];
    int unsigned                mismatches;
    int unsigned                checked;

    function new();
      for (int i = 0; i < NFRAMES; i++) begin
        page_of[i]  = '0;
        valid_of[i] = 1'b0;
        rank_of[i]  = 0;
      end
      fifo_ptr   = NFRAMES - 1;
      hits       = '0;
      misses     = '0;
      policy     = POLICY_FIFO;
      frames_cfg = FRAMES_IN_USE_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_POLICY_MODE:   policy = policy_e'(data[0]);
        CFG_FRAMES_IN_USE: frames_cfg = data[FRAMES_IN_USE_W-1:0];
        default: ;
      endcase
    endfunction

    // Frame f becomes the most recent; valid frames younger than its old rank age by one.
    function void promote(int unsigned f);
      int unsigned old_rank;
      old_rank = valid_of[f] ? rank_of[f] : NFRAMES;
      for (int unsigned i = 0; i < NFRAMES; i++) begin
        if (i != f && valid_of[i] && rank_of[i] < old_rank && rank_of[i] < NFRAMES - 1)
          rank_of[i]++;
      end
      rank_of[f] = 0;
    endfunction

    // Resolves one accepted reference against the frame table and queues its outcome.
    function void note_reference(in_item_t beat);
      int unsigned m;
      int unsigned f;
      bit          found;
      bit          empty;
      out_item_t   o;
      m = (frames_cfg == 0) ? 1 : ((frames_cfg > NFRAMES) ? NFRAMES : frames_cfg);
      o = '0;
      f = 0;
      found = 1'b0;
      empty = 1'b0;
      for (int unsigned i = 0; i < m; i++) begin
        if (!found && valid_of[i] && page_of[i] == beat.page_number) begin
          f = i;
          found = 1'b1;
        end
      end
      if (found) begin
        if (hits != '1) hits++;
        promote(f);
      end else begin
        for (int unsigned i = 0; i < m; i++) begin
          if (!empty && !valid_of[i]) begin
            f = i;
            empty = 1'b1;
          end
        end
        if (empty) begin
          promote(f);
          valid_of[f] = 1'b1;
          page_of[f]  = beat.page_number;
          fifo_ptr    = f;
        end else begin
          if (policy == POLICY_FIFO) begin
            // The pointer may sit above a reduced frame count; it wraps to frame zero.
            f = fifo_ptr + 1;
            if (f >= m) f = 0;
            fifo_ptr = f;
          end else begin
            // Strictly greater keeps the lowest frame on equal ranks.
            f = 0;
            for (int unsigned i = 0; i < m; i++) begin
              if (rank_of[i] > rank_of[f]) f = i;
            end
          end
          o.evicted_valid = 1'b1;
          o.evicted_page  = page_of[f];
          promote(f);
          page_of[f] = beat.page_number;
        end
        if (misses != '1) misses++;
      end
      o.hit         = found;
      o.frame_index = f[FRAME_IDX_W-1:0];
      o.hit_total   = hits;
      o.miss_total  = misses;
      o.end_marker  = beat.last_reference;
      pending_outcomes.push_back(o);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no reference pending", checked));
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("result %0d hit got %0b want %0b",
                                  checked, got.hit, want.hit));
      if (got.frame_index !== want.frame_index)
        report_mismatch($sformatf("result %0d frame_index got %0d want %0d",
                                  checked, got.frame_index, want.frame_index));
      if (got.evicted_valid !== want.evicted_valid)
        report_mismatch($sformatf("result %0d evicted_valid got %0b want %0b",
                                  checked, got.evicted_valid, want.evicted_valid));
      if (got.evicted_page !== want.evicted_page)
        report_mismatch($sformatf("result %0d evicted_page got %h want %h",
                                  checked, got.evicted_page, want.evicted_page));
      if (got.hit_total !== want.hit_total)
        report_mismatch($sformatf("result %0d hit_total got %0d want %0d",
                                  checked, got.hit_total, want.hit_total));
      if (got.miss_total !== want.miss_total)
        report_mismatch($sformatf("result %0d miss_total got %0d want %0d",
                                  checked, got.miss_total, want.miss_total));
      if (got.end_marker !== want.end_marker)
        report_mismatch($sformatf("result %0d end_marker got %0b want %0b",
                                  checked, got.end_marker, want.end_marker));
    endtask

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_stall_o;
  in_item_t               in_item;
  logic                   out_valid_o;
  logic                   out_stall;
  out_item_t              out_item_o;
  logic                   cfg_valid;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  residency_scoreboard sb = new();

  // Handshake between the stimulus process and the receiver for the long hold-off.
  bit          hold_request = 1'b0;
  int unsigned holds_done   = 0;
  int unsigned stall_pct    = 0;

  int unsigned quiet_cycles  = 0;
  int unsigned refs_accepted = 0;
  int unsigned hits_seen     = 0;
  int unsigned evicts_seen   = 0;
  int unsigned config_writes = 0;
  int unsigned input_stalls  = 0;

  page_replacement_fifo_lru_core #(
    .FRAMES(NFRAMES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Monitor. At each rising edge the result beat is checked before the reference beat of the
  // same edge is noted; a reference can never produce its result at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        sb.check_result(out_item_o);
        if (out_item_o.hit) hits_seen++;
        if (out_item_o.evicted_valid) evicts_seen++;
      end
      if (in_valid && in_stall_o) input_stalls++;
      if (in_valid && !in_stall_o) begin
        sb.note_reference(in_item);
        refs_accepted++;
      end
      if ((out_valid_o && !out_stall) || (in_valid && !in_stall_o) ||
          (cfg_valid && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Watchdog: a hang anywhere shows up as a long run of cycles with no beat on any channel.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[%0t] timeout: no beat accepted for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver. It stalls at random with the density the current phase asks for, and on
  // request holds off for a long stretch so that both internal registers fill and the block
  // pushes back on its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
        holds_done++;
      end
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Presents one reference beat from a falling edge and holds it until an edge accepts it.
  // Returns at the falling edge after acceptance, so back-to-back calls keep valid high.
  task automatic offer_page(logic [PAGE_W-1:0] page, logic last);
    bit taken;
    in_valid = 1'b1;
    in_item.page_number    = page;
    in_item.last_reference = last;
    do begin
      @(posedge clk_i);
      taken = !in_stall_o;
      @(negedge clk_i);
    end while (!taken);
  endtask

  // Drops valid for a number of cycles; the idle payload is scrambled since it is ignored.
  task automatic idle_cycles(int unsigned n);
    in_valid = 1'b0;
    in_item  = in_item_t'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  // Waits until every predicted result has been taken, then lets the pipeline settle.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One configuration beat; the scoreboard sees it at the edge that takes it.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do begin
      @(posedge clk_i);
      taken = cfg_ready_o;
    end while (!taken);
    sb.apply_register(idx, data);
    config_writes++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  policy_e     fixed_policy[8] = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
                                   POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO};
  int unsigned fixed_frames[8] = '{16, 1, 1, 0, 31, 5, 3, 16};

  initial begin
    int unsigned           m;
    int unsigned           target;
    int unsigned           burst_left;
    bit                    gaps_on;
    policy_e               pol;
    logic [CFG_DATA_W-1:0] frames_w;
    logic [CFG_DATA_W-1:0] pdata;
    logic [PAGE_W-1:0]     page;
    logic [PAGE_W-1:0]     pool[$];

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, starting from the reset configuration (FIFO, sixteen frames).
    // Page zero must miss even though every frame resets to page zero, since no frame is
    // valid yet. The all-ones page and the end marker are exercised on the way.
    offer_page(16'h0000, 1'b0);
    offer_page(16'hFFFF, 1'b1);
    offer_page(16'h0000, 1'b0);
    offer_page(16'h0001, 1'b0);
    offer_page(16'h0002, 1'b0);
    wait_drained();

    // Two frames in use: frames two and three keep pages 1 and 2 but are not searched.
    // The FIFO pointer sits on frame three, so the next eviction wraps to frame zero.
    write_register(CFG_FRAMES_IN_USE, 5'd2);
    offer_page(16'h0002, 1'b0);
    offer_page(16'hFFFF, 1'b0);
    offer_page(16'h0001, 1'b1);
    wait_drained();

    // Switch to LRU with the ranks that FIFO operation built up.
    write_register(CFG_POLICY_MODE, {4'b0000, POLICY_LRU});
    offer_page(16'h1234, 1'b0);
    offer_page(16'hFFFF, 1'b0);
    offer_page(16'h1234, 1'b0);
    wait_drained();

    // A frame count of zero behaves as a single frame.
    write_register(CFG_FRAMES_IN_USE, 5'd0);
    offer_page(16'h0007, 1'b0);
    offer_page(16'h0007, 1'b0);
    offer_page(16'h0008, 1'b1);
    wait_drained();

    // A count above the frame total is clamped; the stale frames become searchable again.
    // Writes to the unused indexes must change nothing.
    write_register(CFG_FRAMES_IN_USE, 5'd31);
    write_register(2'd2, 5'h1F);
    write_register(2'd3, 5'h15);
    offer_page(16'h0001, 1'b0);
    offer_page(16'h0002, 1'b0);
    offer_page(16'hAAAA, 1'b0);
    offer_page(16'h5555, 1'b1);
    wait_drained();

    // Random part. Each phase picks a configuration, a working set of pages a little
    // larger than the frames in use so that hits, fills and evictions all occur, a sender
    // burst pattern and a receiver stall density. Half the working set carries over, so
    // frames left behind by a smaller count get hit when the count grows again.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 8) begin
        pol      = fixed_policy[phase];
        frames_w = CFG_DATA_W'(fixed_frames[phase]);
      end else begin
        pol = policy_e'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
          frames_w = CFG_DATA_W'($urandom_range(0, 31));
        else
          frames_w = CFG_DATA_W'($urandom_range(1, 16));
      end
      pdata    = CFG_DATA_W'($urandom_range(0, 31));
      pdata[0] = pol;
      write_register(CFG_POLICY_MODE, pdata);
      write_register(CFG_FRAMES_IN_USE, frames_w);
      if ($urandom_range(0, 2) == 0)
        write_register(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom_range(0, 31)));

      m = (frames_w == 0) ? 1 : ((frames_w > NFRAMES) ? NFRAMES : frames_w);
      target = m + $urandom_range(1, m + 2);
      while (pool.size() > target / 2) void'(pool.pop_front());
      while (pool.size() < target) pool.push_back(PAGE_W'($urandom_range(0, 65535)));

      case (phase % 4)
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 10;
      endcase
      gaps_on = (phase % 3 != 0);
      // In the second phase the receiver holds off while the sender keeps offering beats in
      // its bursts, so the block fills up and raises its input stall.
      if (phase == 1) hold_request = 1'b1;

      burst_left = 0;
      for (int unsigned k = 0; k < PHASE_REFS; k++) begin
        if (burst_left == 0) begin
          if (gaps_on) idle_cycles($urandom_range(1, 6));
          burst_left = $urandom_range(1, 20);
        end
        if ($urandom_range(0, 99) < 88)
          page = pool[$urandom_range(0, pool.size() - 1)];
        else
          page = PAGE_W'($urandom_range(0, 65535));
        offer_page(page, ($urandom_range(0, 15) == 0));
        burst_left--;
      end
      // The sender pauses here until every outstanding result has come back, which also
      // makes the next phase's register writes safe.
      wait_drained();
    end

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);

    $display("Covered %0d references in %0d random phases plus a directed set",
             refs_accepted, RANDOM_PHASES);
    $display("(%0d hits, %0d evictions, %0d register writes, %0d long holds, %0d stalled %s",
             hits_seen, evicts_seen, config_writes, holds_done, input_stalls,
             $sformatf("input cycles), %0d mismatches.", sb.mismatches));
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ page_replacement_fifo_lru_core.f @@
hdl/pgr_pkg.sv
hdl/pgr_frame_select.sv
hdl/pgr_frame_store.sv
hdl/pgr_totals.sv
hdl/page_replacement_fifo_lru_core.sv
hdl/pgr_checker.sv
tb/sv/tb_page_replacement_fifo_lru_core.sv
